// ===== hdl/mfcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfcrc_pkg;

  // field and register widths
  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY     = 4'd1;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0] FRAME_LENGTH_RESET = 8'd16;
  localparam logic [CRC_W-1:0]  CRC_POLY_RESET     = 16'h8005;

  // frame mark and number of marks that open a frame
  localparam logic [BYTE_W-1:0] MARK_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] MARK_COUNT = 8'd3;

  // crc after the first two marks from a zero start: the top bit never
  // reaches the msb in those 16 shifts, so no polynomial term enters
  localparam logic [CRC_W-1:0] MARK_PAIR_CRC = 16'h5555;

  // item passed from the frame parser to the crc check stage
  typedef struct packed {
    logic              valid;
    logic              is_status;
    logic [BYTE_W-1:0] data;
    logic [CRC_W-1:0]  crc_half;
    logic [CRC_W-1:0]  rx_crc;
  } stage_t;

  // one augmented crc step, input bit enters at the lsb
  function automatic logic [CRC_W-1:0] crc_shift_bit(input logic [CRC_W-1:0] r,
                                                     input logic in_bit,
                                                     input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] n;
    n = {r[CRC_W-2:0], in_bit};
    if (r[CRC_W-1]) begin
      n = n ^ poly;
    end
    return n;
  endfunction

  // feed one byte, lsb first
  function automatic logic [CRC_W-1:0] crc_feed_byte(input logic [CRC_W-1:0] r,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] acc;
    acc = r;
    for (int k = 0; k < BYTE_W; k++) begin
      acc = crc_shift_bit(acc, b[k], poly);
    end
    return acc;
  endfunction

  // bit-reverse the crc register
  function automatic logic [CRC_W-1:0] crc_reverse(input logic [CRC_W-1:0] r);
    logic [CRC_W-1:0] rev;
    for (int k = 0; k < CRC_W; k++) begin
      rev[k] = r[CRC_W-1-k];
    end
    return rev;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mfcrc_rx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfcrc_rx_if;
  import mfcrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// ===== hdl/mfcrc_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfcrc_res_if;
  import mfcrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_status;
  logic              frame_ok;
  logic              last;

  modport source (output valid, output out_byte, output is_status, output frame_ok,
                  output last, input ready);
  modport sink (input valid, input out_byte, input is_status, input frame_ok,
                input last, output ready);

endinterface

`default_nettype wire

// ===== hdl/mfcrc_frame_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfcrc_frame_fsm
  import mfcrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  mfcrc_rx_if.sink               rx,
  input  wire logic [BYTE_W-1:0] frame_length,
  input  wire logic [CRC_W-1:0]  crc_poly,
  input  wire logic              s1_ready,
  output stage_t                 s1
);

  // phase codes; unused codes behave as hunting with no marks
  localparam logic [2:0] PH_HUNT0  = 3'd0;
  localparam logic [2:0] PH_HUNT2  = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_CRC_LO = 3'd4;
  localparam logic [2:0] PH_CRC_HI = 3'd5;

  logic              in_v;
  logic [BYTE_W-1:0] in_b;
  logic              proc;

  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic [BYTE_W-1:0] body_count;
  logic [BYTE_W-1:0] body_count_next;
  logic [CRC_W-1:0]  crc_reg;
  logic [CRC_W-1:0]  crc_reg_next;
  logic [BYTE_W-1:0] crc_low_byte;
  logic [BYTE_W-1:0] crc_low_byte_next;
  logic [BYTE_W-1:0] body_len;
  logic [BYTE_W-1:0] body_count_inc;
  logic [2:0]        marks;
  stage_t            s1_next;

  // the parser takes the held byte once the next stage has room
  assign proc     = in_v && s1_ready;
  assign rx.ready = !in_v || proc;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (rx.ready) begin
      in_v <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_b <= rx.rx_byte;
    end
  end

  // body length, short frame lengths act as marks only
  assign body_len       = (frame_length < MARK_COUNT) ? '0 : frame_length - MARK_COUNT;
  assign body_count_inc = body_count + 8'd1;
  assign marks          = (phase > PH_HUNT2) ? PH_HUNT0 : phase;

  // frame parser
  always_comb begin
    phase_next         = phase;
    body_count_next    = body_count;
    crc_reg_next       = crc_reg;
    crc_low_byte_next  = crc_low_byte;
    s1_next            = '0;
    s1_next.data       = in_b;
    s1_next.crc_half   = crc_feed_byte(crc_reg, '0, crc_poly);
    s1_next.rx_crc     = {in_b, crc_low_byte};
    case (phase)
      PH_BODY: begin
        if (body_count >= body_len) begin
          // length shrank under the frame: this byte is the crc low byte
          crc_low_byte_next = in_b;
          phase_next        = PH_CRC_HI;
        end else begin
          crc_reg_next    = crc_feed_byte(crc_reg, in_b, crc_poly);
          body_count_next = body_count_inc;
          if (body_count_inc >= body_len) begin
            phase_next = PH_CRC_LO;
          end
          s1_next.valid = 1'b1;
        end
      end
      PH_CRC_LO: begin
        crc_low_byte_next = in_b;
        phase_next        = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        s1_next.valid     = 1'b1;
        s1_next.is_status = 1'b1;
        s1_next.data      = '0;
        phase_next        = PH_HUNT0;
        body_count_next   = '0;
      end
      default: begin
        // hunting for the run of marks
        if (in_b != MARK_BYTE) begin
          phase_next = PH_HUNT0;
        end else if (marks < PH_HUNT2) begin
          phase_next = marks + 3'd1;
        end else begin
          crc_reg_next    = crc_feed_byte(MARK_PAIR_CRC, MARK_BYTE, crc_poly);
          body_count_next = '0;
          phase_next      = (body_len == '0) ? PH_CRC_LO : PH_BODY;
        end
      end
    endcase
    if (!proc) begin
      s1_next.valid = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT0;
      body_count   <= '0;
      crc_reg      <= '0;
      crc_low_byte <= '0;
    end else if (proc) begin
      phase        <= phase_next;
      body_count   <= body_count_next;
      crc_reg      <= crc_reg_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  // stage register toward the crc check
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (s1_ready) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mfcrc_crc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfcrc_crc_check
  import mfcrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stage_t           s1,
  input  wire logic [CRC_W-1:0] crc_poly,
  output logic                  s1_ready,
  mfcrc_res_if.source           res
);

  logic              out_v;
  logic [BYTE_W-1:0] out_b;
  logic              out_status;
  logic              out_ok;
  logic [CRC_W-1:0]  crc_final;
  logic              ok;

  // last eight zero shifts, bit reverse and compare
  assign crc_final = crc_reverse(crc_feed_byte(s1.crc_half, '0, crc_poly));
  assign ok        = s1.is_status && (crc_final == s1.rx_crc);

  assign s1_ready = !out_v || res.ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s1_ready) begin
      out_v <= s1.valid;
    end
    if (s1_ready && s1.valid) begin
      out_b      <= s1.data;
      out_status <= s1.is_status;
      out_ok     <= ok;
    end
  end

  assign res.valid     = out_v;
  assign res.out_byte  = out_b;
  assign res.is_status = out_status;
  assign res.frame_ok  = out_ok;
  assign res.last      = out_status;

endmodule

`default_nettype wire

// ===== hdl/marked_frame_crc16_receiver_top.sv =====
// Marked-frame CRC-16 receiver.
// rx channel: one received byte per item (valid/ready). The block hunts for
// three 0xAA marks in a row, forwards frame_length - 3 body bytes on the res
// channel, then takes the CRC low and high bytes and emits one status item
// (is_status = last = 1, frame_ok = CRC match). Bytes outside a frame and
// the CRC bytes give no result item.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 frame_length, 1 crc_poly); other indexes are ignored.
// A result reaches res from its accepted byte through the input register, the
// parser register and the result register.
// Throughput: one byte per cycle while res is ready; the byte-wide CRC update in
// the parser and the two eight-bit halves of the final zero flush set that figure.
// Reset (rst, synchronous): hunting with no marks, config at 16 and 0x8005.
// When res stalls with a result waiting, the result and parser registers hold
// and at most one more byte is taken into the input register before rx.ready
// drops.
`timescale 1ns / 1ps
`default_nettype none

module marked_frame_crc16_receiver_top
  import mfcrc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  mfcrc_rx_if.sink                    rx,
  mfcrc_res_if.source                 res
);

  logic [BYTE_W-1:0] frame_length;
  logic [CRC_W-1:0]  crc_poly;
  stage_t            s1;
  logic              s1_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_LENGTH_RESET;
      crc_poly     <= CRC_POLY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LENGTH: frame_length <= cfg_data[BYTE_W-1:0];
        REG_CRC_POLY:     crc_poly     <= cfg_data[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  mfcrc_frame_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .frame_length (frame_length),
    .crc_poly     (crc_poly),
    .s1_ready     (s1_ready),
    .s1           (s1)
  );

  mfcrc_crc_check u_check (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .crc_poly (crc_poly),
    .s1_ready (s1_ready),
    .res      (res)
  );

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  // status items carry no byte and close the frame
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.is_status |-> res.last && (res.out_byte == '0))
    else $error("malformed status item");

  // body items carry no status flags
  a_body_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.is_status |-> !res.frame_ok && !res.last)
    else $error("malformed body item");

  // a parsed item waiting behind a stalled result is kept
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1.valid && res.valid && !res.ready |=> s1.valid)
    else $error("parsed item lost during stall");

endmodule

`default_nettype wire
